// ----- hdl/kcs_pkg.sv -----
`timescale 1ns / 1ps

package kcs_pkg;

  // Fixed field and register widths.
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned NODE_W     = 6;
  localparam int unsigned CSIZE_W    = 5;
  localparam int unsigned NCOUNT_W   = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_NODES_DEF  = 64;
  localparam int unsigned MAX_CLIQUE_DEF = 16;

  // Register reset values.
  localparam logic [CSIZE_W-1:0]  CLIQUE_SIZE_RST = 5'd3;
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST  = 7'd64;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CLIQUE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD_EDGE = 2'd0,
    FUNC_SEARCH   = 2'd1,
    FUNC_CLEAR    = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_RD_A,
    S_EDGE_WR_A,
    S_EDGE_WR_B,
    S_START,
    S_EXPAND,
    S_LOAD,
    S_POP,
    S_FOUND,
    S_FAIL
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear_all;
    logic edge_wr_a;
    logic edge_wr_b;
    logic init;
    logic expand;
    logic load;
    logic pop_rd;
    logic pop_ld;
    logic out_load;
    logic out_found;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_ok;
    logic cur_empty;
    logic depth_zero;
    logic next_at_k;
    logic k_zero;
    logic k_over;
    logic out_busy;
  } sts_t;

endpackage

// ----- hdl/kcs_if.sv -----
`timescale 1ns / 1ps

interface kcs_in_if import kcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, output func, output node_a, output node_b, input ready);
  modport sink (input valid, input func, input node_a, input node_b, output ready);
endinterface

interface kcs_out_if ();
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, output found, input ready);
  modport sink (input valid, input found, output ready);
endinterface

// ----- hdl/kcs_ram.sv -----
`timescale 1ns / 1ps

module kcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/kcs_ctrl.sv -----
`timescale 1ns / 1ps

module kcs_ctrl import kcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] in_func_i,
  output logic              in_ready_o,
  input  sts_t              sts_i,
  output cmd_t              cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (in_func_i)
            FUNC_ADD_EDGE: state_d = S_EDGE_RD_A;
            FUNC_SEARCH:   state_d = S_START;
            FUNC_CLEAR:    cmd_o.clear_all = 1'b1;
            default:       state_d = S_IDLE;
          endcase
        end
      end
      S_EDGE_RD_A: begin
        state_d = sts_i.edge_ok ? S_EDGE_WR_A : S_IDLE;
      end
      S_EDGE_WR_A: begin
        cmd_o.edge_wr_a = 1'b1;
        state_d = S_EDGE_WR_B;
      end
      S_EDGE_WR_B: begin
        cmd_o.edge_wr_b = 1'b1;
        state_d = S_IDLE;
      end
      S_START: begin
        priority if (sts_i.k_zero) begin
          state_d = S_FOUND;
        end else if (sts_i.k_over) begin
          state_d = S_FAIL;
        end else begin
          cmd_o.init = 1'b1;
          state_d = S_EXPAND;
        end
      end
      S_EXPAND: begin
        priority if (!sts_i.cur_empty) begin
          cmd_o.expand = 1'b1;
          state_d = S_LOAD;
        end else if (sts_i.depth_zero) begin
          state_d = S_FAIL;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d = S_POP;
        end
      end
      S_LOAD: begin
        if (sts_i.next_at_k) begin
          state_d = S_FOUND;
        end else begin
          cmd_o.load = 1'b1;
          state_d = S_EXPAND;
        end
      end
      S_POP: begin
        cmd_o.pop_ld = 1'b1;
        state_d = S_EXPAND;
      end
      S_FOUND: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_found = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FAIL: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/kcs_dp.sv -----
`timescale 1ns / 1ps

module kcs_dp import kcs_pkg::*; #(
  parameter int unsigned MAX_NODES  = MAX_NODES_DEF,
  parameter int unsigned MAX_CLIQUE = MAX_CLIQUE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [NODE_W-1:0]     in_node_a_i,
  input  logic [NODE_W-1:0]     in_node_b_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_found_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned DW = $clog2(MAX_CLIQUE + 1);
  localparam int unsigned CW = (MAX_CLIQUE > 1) ? $clog2(MAX_CLIQUE) : 1;

  logic [CSIZE_W-1:0]   clique_size_q;
  logic [NCOUNT_W-1:0]  node_count_q;
  logic [NODE_W-1:0]    a_q, b_q;
  logic [MAX_NODES-1:0] row_valid_q;
  logic                 rd_valid_q;
  logic [MAX_NODES-1:0] cur_q, rem_q;
  logic [DW-1:0]        depth_q, k_q;
  logic                 out_valid_q, found_q;

  logic [MAX_NODES-1:0] onehot, rem, mask, row, bit_a, bit_b;
  logic [NW-1:0]        v_idx, addr_a, addr_b, adj_raddr, adj_waddr;
  logic [MAX_NODES-1:0] adj_wdata, adj_rdata, cand_rdata;
  logic                 adj_we;
  logic [DW-1:0]        depth_m1;
  logic [DW:0]          depth_p1;

  assign addr_a = NW'(a_q);
  assign addr_b = NW'(b_q);
  assign bit_a  = MAX_NODES'(1) << a_q;
  assign bit_b  = MAX_NODES'(1) << b_q;

  // Lowest candidate and the candidates left above it.
  assign onehot = cur_q & (~cur_q + MAX_NODES'(1));
  assign rem    = cur_q & (cur_q - MAX_NODES'(1));

  always_comb begin
    v_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      v_idx = v_idx | (onehot[i] ? NW'(i) : NW'(0));
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      mask[i] = 32'(node_count_q) > i;
    end
  end

  // A row that was never written since the last clear reads as zero.
  assign row = rd_valid_q ? adj_rdata : '0;

  always_comb begin
    priority if (cmd_i.expand) begin
      adj_raddr = v_idx;
    end else if (cmd_i.edge_wr_a) begin
      adj_raddr = addr_b;
    end else begin
      adj_raddr = addr_a;
    end
  end

  assign adj_we    = cmd_i.edge_wr_a | cmd_i.edge_wr_b;
  assign adj_waddr = cmd_i.edge_wr_a ? addr_a : addr_b;
  assign adj_wdata = row | (cmd_i.edge_wr_a ? bit_b : bit_a);

  kcs_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  assign depth_m1 = depth_q - DW'(1);
  assign depth_p1 = (DW + 1)'(depth_q) + (DW + 1)'(1);

  kcs_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_CLIQUE)
  ) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.expand),
    .waddr_i (depth_q[CW-1:0]),
    .wdata_i (rem),
    .raddr_i (depth_m1[CW-1:0]),
    .rdata_o (cand_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clique_size_q <= CLIQUE_SIZE_RST;
      node_count_q  <= NODE_COUNT_RST;
      row_valid_q   <= '0;
      depth_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CLIQUE_SIZE: clique_size_q <= cfg_data_i[CSIZE_W-1:0];
          CFG_NODE_COUNT:  node_count_q  <= cfg_data_i;
          default:         node_count_q  <= node_count_q;
        endcase
      end
      if (cmd_i.clear_all) begin
        row_valid_q <= '0;
      end else if (adj_we) begin
        row_valid_q[adj_waddr] <= 1'b1;
      end
      priority if (cmd_i.init) begin
        depth_q <= '0;
      end else if (cmd_i.load) begin
        depth_q <= depth_p1[DW-1:0];
      end else if (cmd_i.pop_rd) begin
        depth_q <= depth_m1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_valid_q <= row_valid_q[adj_raddr];
    if (cmd_i.capture) begin
      a_q <= in_node_a_i;
      b_q <= in_node_b_i;
    end
    if (cmd_i.init) begin
      k_q <= DW'(clique_size_q);
    end
    priority if (cmd_i.init) begin
      cur_q <= mask;
    end else if (cmd_i.load) begin
      cur_q <= rem_q & row;
    end else if (cmd_i.pop_ld) begin
      cur_q <= cand_rdata;
    end
    if (cmd_i.expand) begin
      rem_q <= rem;
    end
    if (cmd_i.out_load) begin
      found_q <= cmd_i.out_found;
    end
  end

  assign sts_o.edge_ok    = (a_q != b_q) && (32'(a_q) < MAX_NODES) && (32'(b_q) < MAX_NODES);
  assign sts_o.cur_empty  = (cur_q == '0);
  assign sts_o.depth_zero = (depth_q == '0);
  assign sts_o.next_at_k  = (depth_p1 == (DW + 1)'(k_q));
  assign sts_o.k_zero     = (clique_size_q == '0);
  assign sts_o.k_over     = (32'(clique_size_q) > MAX_CLIQUE);
  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_found_o = found_q;

  a_expand_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.expand |-> (cur_q != '0))
    else $error("expand issued with no candidate left");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(depth_q) <= MAX_CLIQUE)
    else $error("search depth beyond stack capacity");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before its transfer");

  a_clear_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_all |=> (row_valid_q == '0))
    else $error("rows still valid after a clear");

endmodule

// ----- hdl/k_clique_search.sv -----
`timescale 1ns / 1ps

// k-clique search engine. The block keeps an undirected graph of up to MAX_NODES
// nodes as an adjacency bit matrix in a RAM, one row per node; per-row valid bits
// make the matrix read as empty right after reset and after a clear, so no clearing
// pass is needed. An input item with func add-edge sets both directions of an edge
// (self loops and endpoints at or above MAX_NODES are dropped): it reads the row of
// the first node, writes it back with the new bit, then writes the row of the
// second node, and only then can the next item be taken. A clear drops all row
// valid bits at its transfer. A search runs a depth-first backtracking walk over
// the candidate sets and returns a single found bit: it checks the size and loads
// the node range, then for each node tried picks the lowest candidate and reads its
// adjacency row through the single RAM read port, then intersects; each backtrack
// step reads the saved candidate set of the level below, and when no clique exists
// the walk ends once the top level runs dry. The answer is handed to the output
// register once that register is free. The search time therefore depends on the
// graph and can grow exponentially with node_count and clique_size; the repeated
// pick-and-intersect step sets it. Items are taken one at a time, but a new item
// can be taken while a finished result still waits in the output register for its
// transfer. Configuration writes are meant to happen while the block is idle.

module k_clique_search import kcs_pkg::*; #(
  parameter int unsigned MAX_NODES  = MAX_NODES_DEF,
  parameter int unsigned MAX_CLIQUE = MAX_CLIQUE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kcs_in_if.sink                in_if,
  kcs_out_if.source             out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences edge updates and the search; it never looks at payload
  // beyond the function code.
  kcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_func_i  (in_if.func),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the adjacency RAM, the candidate-set stack, the search depth,
  // the configuration registers and the output register.
  kcs_dp #(
    .MAX_NODES  (MAX_NODES),
    .MAX_CLIQUE (MAX_CLIQUE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_node_a_i (in_if.node_a),
    .in_node_b_i (in_if.node_b),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_found_o (out_if.found)
  );

endmodule
